>>> hw/rtl/census_transform_8x8_assert.svh
// Assertion macros for the census transform block.
// Define ASSERT_OFF to compile the checks away.
`ifndef CENSUS_TRANSFORM_8X8_ASSERT_SVH
`define CENSUS_TRANSFORM_8X8_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that is muted while reset is high
`define CT8_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also runs through reset
`define CT8_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CT8_ASSERT(label, clk, rst, prop, msg)
`define CT8_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> hw/rtl/ct8_pkg.sv
`timescale 1ns / 1ps

package ct8_pkg;

  // Image size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Window geometry: 8x8, centre at offset 4, lag of 3 scan steps
  localparam int WIN        = 8;
  localparam int CTR        = 4;
  localparam int LAG        = WIN - 1 - CTR;
  localparam int STORE_ROWS = WIN - 1;
  localparam int CODE_W     = WIN * WIN - 1;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int POS_W  = 10;
  localparam int SLOT_W = $clog2(STORE_ROWS);
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int DIM_W  = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + LAG);

  // Configuration register indexes
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

  // One column of the line store: one pixel per stored row
  typedef logic [STORE_ROWS-1:0][PIX_W-1:0] col_t;

  // Neighbor validity for one centre
  typedef struct packed {
    logic [WIN-1:0] rm;
    logic [WIN-1:0] cm;
    logic           in_img;
  } mask_t;

  // Result sideband
  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } info_t;

  // Stage after the transfer, line store read in flight
  typedef struct packed {
    logic [PIX_W-1:0]  px;
    logic [SLOT_W-1:0] slot;
    logic [WIN-1:0]    ld;
    mask_t             mask;
    info_t             info;
  } s1_t;

  // Stage after the window shift
  typedef struct packed {
    mask_t mask;
    info_t info;
  } s2_t;

  // Zero acts as one, oversize clamps to the limit
  function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int limit);
    logic [DIM_W-1:0] s;
    if (v == '0) s = DIM_W'(1);
    else if (int'(v) > limit) s = DIM_W'(limit);
    else s = DIM_W'(v);
    return s;
  endfunction

endpackage

>>> hw/rtl/ct8_line_store.sv
`timescale 1ns / 1ps

// Seven-row line store, one word per column, one byte lane per row slot.
// Read-first: a read and a write at the same column return the old word.
module ct8_line_store (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [ct8_pkg::ADDR_W-1:0]   addr,
  input  logic                         wr_en,
  input  logic [ct8_pkg::SLOT_W-1:0]   wr_slot,
  input  logic [ct8_pkg::PIX_W-1:0]    wr_data,
  output ct8_pkg::col_t                rd_data
);

  ct8_pkg::col_t mem [ct8_pkg::MAX_WIDTH];

  // Registered read, byte-lane write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
    if (wr_en) begin
      mem[addr][wr_slot] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/ct8_window.sv
`timescale 1ns / 1ps

// 8x8 window registers and the 63 parallel comparisons against the centre.
module ct8_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift_en,
  input  logic [ct8_pkg::PIX_W-1:0]     px,
  input  logic [ct8_pkg::SLOT_W-1:0]    slot,
  input  logic [ct8_pkg::WIN-1:0]       ld,
  input  ct8_pkg::col_t                 rd_data,
  input  ct8_pkg::mask_t                mask,
  output logic [ct8_pkg::CODE_W-1:0]    code
);

  localparam int WIN = ct8_pkg::WIN;
  localparam int SR  = ct8_pkg::STORE_ROWS;
  localparam int SLW = ct8_pkg::SLOT_W;
  localparam int WW  = WIN * WIN;
  localparam int CI  = WW - 1 - (ct8_pkg::CTR * WIN + ct8_pkg::CTR);

  logic [WIN-1:0][WIN-1:0][ct8_pkg::PIX_W-1:0] win;
  logic [WIN-1:0][ct8_pkg::PIX_W-1:0]          load;
  logic [WW-1:0]                               full;

  // New right column: stored row (r-7+dr) sits in slot (r+dr) mod 7
  always_comb begin
    logic [SLW:0] s;
    s = '0;
    for (int dr = 0; dr < SR; dr++) begin
      s = {1'b0, slot} + (SLW + 1)'(dr);
      if (s >= (SLW + 1)'(SR)) s = s - (SLW + 1)'(SR);
      load[dr] = ld[dr] ? rd_data[s[SLW-1:0]] : '0;
    end
    load[WIN-1] = ld[WIN-1] ? px : '0;
  end

  // Shift left one column per item
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (shift_en) begin
      for (int dr = 0; dr < WIN; dr++) begin
        for (int dc = 0; dc < WIN - 1; dc++) begin
          win[dr][dc] <= win[dr][dc + 1];
        end
        win[dr][WIN-1] <= load[dr];
      end
    end
  end

  // Brighter-than-centre bits, masked by image bounds
  always_comb begin
    full = '0;
    for (int dr = 0; dr < WIN; dr++) begin
      for (int dc = 0; dc < WIN; dc++) begin
        full[WW - 1 - (dr * WIN + dc)] = mask.in_img && mask.rm[dr] && mask.cm[dc] &&
                                         (win[dr][dc] > win[ct8_pkg::CTR][ct8_pkg::CTR]);
      end
    end
  end

  // Drop the centre position
  assign code = {full[WW-1:CI+1], full[CI-1:0]};

endmodule

>>> hw/rtl/census_transform_8x8.sv
`timescale 1ns / 1ps
`include "census_transform_8x8_assert.svh"

// Streaming 8x8 census transform.
// Input: one grey pixel per transfer on in_valid/in_ready, raster order over
// (image_height+3) x (image_width+3) scan positions; pixels outside the image
// are ignored. Each transfer at scan row >= 3 and column >= 3 yields one result
// on out_valid/out_ready: the 63-bit code for centre (row-3, col-3), its
// position, and frame_last on the final centre of the frame.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 width,
// 1 height); write only while the block is idle.
// Throughput: one pixel per clock while out_ready stays high. The line store is one memory
// with one column word read and one byte lane written per cycle.
// Path: a pixel transfer registers the store read and stage 1, the window shift
// fills stage 2, and the compare result is held in the output register.
// Stall: while out_ready is low the block still takes up to two more pixels
// into its internal stages, then drops in_ready.
// Reset: scan position to the frame start, size to 640x480, window cleared,
// pipeline empty. The line store is not cleared; each entry is written
// before it is read within a frame.
module census_transform_8x8 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ct8_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ct8_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ct8_pkg::PIX_W-1:0]     pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ct8_pkg::CODE_W-1:0]    census_code,
  output logic [ct8_pkg::POS_W-1:0]     center_row,
  output logic [ct8_pkg::POS_W-1:0]     center_col,
  output logic                          frame_last
);

  localparam int DW  = ct8_pkg::DIM_W;
  localparam int SW  = DW + 1;
  localparam int AW  = ct8_pkg::ADDR_W;
  localparam int SLW = ct8_pkg::SLOT_W;
  localparam int PW  = ct8_pkg::POS_W;
  localparam int WIN = ct8_pkg::WIN;
  localparam int LAG = ct8_pkg::LAG;
  localparam int SR  = ct8_pkg::STORE_ROWS;

  logic [ct8_pkg::CFG_W-1:0] image_width, image_height;
  logic [DW-1:0]             scan_row, scan_col;
  logic [SLW-1:0]            scan_slot;

  logic [DW-1:0]  ew, eh;
  logic [SW-1:0]  r_x, c_x, ew_x, eh_x;
  logic [WIN-1:0] rm, cm;
  logic           col_in, row_in, row_end, frame_end, emit, in_img;

  logic           s1_valid, s2_valid;
  ct8_pkg::s1_t   s1, s1_next;
  ct8_pkg::s2_t   s2;
  logic           en0, en1, en2, in_acc, shift;

  ct8_pkg::col_t               rd_data;
  logic [ct8_pkg::CODE_W-1:0]  code;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ct8_pkg::WIDTH_RST;
      image_height <= ct8_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ct8_pkg::REG_WIDTH:  image_width  <= cfg_data;
        ct8_pkg::REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective size and scan-position decode
  assign ew   = ct8_pkg::eff_size(image_width, ct8_pkg::MAX_WIDTH);
  assign eh   = ct8_pkg::eff_size(image_height, ct8_pkg::MAX_HEIGHT);
  assign r_x  = {1'b0, scan_row};
  assign c_x  = {1'b0, scan_col};
  assign ew_x = {1'b0, ew};
  assign eh_x = {1'b0, eh};

  assign col_in    = scan_col < ew;
  assign row_in    = scan_row < eh;
  assign row_end   = c_x >= ew_x + SW'(LAG - 1);
  assign frame_end = row_end && (r_x >= eh_x + SW'(LAG - 1));
  assign emit      = (scan_row >= DW'(LAG)) && (scan_col >= DW'(LAG));
  assign in_img    = (r_x < eh_x + SW'(LAG)) && (c_x < ew_x + SW'(LAG));

  // Row and column bounds of the window offsets
  always_comb begin
    logic [SW-1:0] rs, cs;
    rs = '0;
    cs = '0;
    for (int k = 0; k < WIN; k++) begin
      rs    = r_x + SW'(k);
      cs    = c_x + SW'(k);
      rm[k] = (rs >= SW'(SR)) && (rs < eh_x + SW'(SR));
      cm[k] = (cs >= SW'(SR)) && (cs < ew_x + SW'(SR));
    end
  end

  // Stage 1 contents for the pixel being taken
  always_comb begin
    s1_next.px          = pixel;
    s1_next.slot        = scan_slot;
    s1_next.ld          = col_in ? rm : '0;
    s1_next.mask.rm     = rm;
    s1_next.mask.cm     = cm;
    s1_next.mask.in_img = in_img;
    s1_next.info.emit   = emit;
    s1_next.info.row    = PW'(scan_row - DW'(LAG));
    s1_next.info.col    = PW'(scan_col - DW'(LAG));
    s1_next.info.last   = frame_end;
  end

  // Stage enables: each stage moves when the one after it has room
  assign en2      = !out_valid || out_ready;
  assign en1      = !s2_valid || en2;
  assign en0      = !s1_valid || en1;
  assign in_ready = en0;
  assign in_acc   = in_valid && in_ready;
  assign shift    = s1_valid && en1;

  // Scan position, wraps at row and frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row  <= '0;
      scan_col  <= '0;
      scan_slot <= '0;
    end else if (in_acc) begin
      priority if (frame_end) begin
        scan_row  <= '0;
        scan_col  <= '0;
        scan_slot <= '0;
      end else if (row_end) begin
        scan_col  <= '0;
        scan_row  <= scan_row + DW'(1);
        scan_slot <= (scan_slot == SLW'(SR - 1)) ? '0 : scan_slot + SLW'(1);
      end else begin
        scan_col  <= scan_col + DW'(1);
      end
    end
  end

  // Line store: read the column, store the pixel of an image row
  ct8_line_store u_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .addr    (scan_col[AW-1:0]),
    .wr_en   (in_acc && col_in && row_in),
    .wr_slot (scan_slot),
    .wr_data (pixel),
    .rd_data (rd_data)
  );

  // Window and comparisons
  ct8_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (shift),
    .px       (s1.px),
    .slot     (s1.slot),
    .ld       (s1.ld),
    .rd_data  (rd_data),
    .mask     (s2.mask),
    .code     (code)
  );

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en0) s1_valid <= in_valid;
      if (en1) s2_valid <= s1_valid;
      if (en2) out_valid <= s2_valid && s2.info.emit;
    end
  end

  // Pipeline payload and output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1 <= s1_next;
    end
    if (shift) begin
      s2.mask <= s1.mask;
      s2.info <= s1.info;
    end
    if (en2 && s2_valid && s2.info.emit) begin
      census_code <= code;
      center_row  <= s2.info.row;
      center_col  <= s2.info.col;
      frame_last  <= s2.info.last;
    end
  end

  // Checks
  `CT8_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !s1_valid && !s2_valid && !out_valid, "pipeline not empty after reset")
  `CT8_ASSERT(a_stall_full, clk, rst, !in_ready |-> s1_valid && s2_valid && out_valid && !out_ready, "input stalled with room in pipeline")
  `CT8_ASSERT(a_frame_wrap, clk, rst, in_acc && frame_end |=> scan_row == '0 && scan_col == '0 && scan_slot == '0, "scan did not wrap at frame end")
  `CT8_ASSERT(a_scan_range, clk, rst, scan_slot < SLW'(SR) && c_x <= SW'(ct8_pkg::MAX_WIDTH + LAG - 1), "scan position out of range")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int IDX_W      = ct8_pkg::IDX_W;
  localparam int CODE_W     = ct8_pkg::CODE_W;
  localparam int POS_W      = ct8_pkg::POS_W;
  localparam int CFG_W      = ct8_pkg::CFG_W;
  localparam int PIX_W      = ct8_pkg::PIX_W;
  localparam int STORE_ROWS = ct8_pkg::STORE_ROWS;
  localparam int MAX_WIDTH  = ct8_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = ct8_pkg::MAX_HEIGHT;
  localparam int WIN        = ct8_pkg::WIN;
  localparam int CTR        = ct8_pkg::CTR;
  localparam int LAG        = ct8_pkg::LAG;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int ERR_PRINT_MAX = 40;

  typedef enum int {PIX_UNIFORM, PIX_NEAR, PIX_BINARY} pix_style_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } census_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  pixel = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] census_code;
  logic [POS_W-1:0]  center_row;
  logic [POS_W-1:0]  center_col;
  logic              frame_last;

  census_transform_8x8 dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .census_code (census_code),
    .center_row  (center_row),
    .center_col  (center_col),
    .frame_last  (frame_last)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block state
  logic [PIX_W-1:0] line_mem [0:STORE_ROWS*MAX_WIDTH-1];
  logic [PIX_W-1:0] win_px [0:WIN-1][0:WIN-1];
  int               scan_r;
  int               scan_c;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  census_result_t   pending_codes [$];
  int               err_count = 0;
  int               items_sent = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_req = 0;
  int               hold_left = 0;
  logic [PIX_W-1:0] px_base = '0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= ERR_PRINT_MAX) $display("%0t ns: ERROR %s", $time, msg);
  endtask

  // Zero acts as one, oversize is limited
  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lim);
    int s;
    s = int'(v);
    if (s < 1) s = 1;
    if (s > lim) s = lim;
    return s;
  endfunction

  // Advance the shadow state by one accepted pixel and queue any code it yields
  task automatic census_predict(input logic [PIX_W-1:0] px);
    int             ew, eh, r, c, q, cr, cc, idx, nr, nc;
    bit             col_in, row_end, frame_end;
    logic [PIX_W-1:0] v, centre;
    census_result_t res;
    ew = clamp_dim(width_reg, MAX_WIDTH);
    eh = clamp_dim(height_reg, MAX_HEIGHT);
    r = scan_r;
    c = scan_c;
    col_in = (c < ew);

    // shift window left, load new right column
    for (int dr = 0; dr < WIN; dr++) begin
      q = r - (WIN - 1) + dr;
      v = '0;
      for (int dc = 0; dc < WIN - 1; dc++) win_px[dr][dc] = win_px[dr][dc+1];
      if (col_in && q >= 0 && q < eh) begin
        if (dr == WIN - 1) v = px;
        else v = line_mem[(q % STORE_ROWS) * MAX_WIDTH + c];
      end
      win_px[dr][WIN-1] = v;
    end
    if (col_in && r < eh) line_mem[(r % STORE_ROWS) * MAX_WIDTH + c] = px;

    row_end = (c >= ew + 2);
    frame_end = row_end && (r >= eh + 2);

    if (r >= LAG && c >= LAG) begin
      cr = r - LAG;
      cc = c - LAG;
      res.code = '0;
      if (cr < eh && cc < ew) begin
        centre = win_px[CTR][CTR];
        idx = 0;
        for (int dr = 0; dr < WIN; dr++) begin
          for (int dc = 0; dc < WIN; dc++) begin
            if (!(dr == CTR && dc == CTR)) begin
              nr = cr + dr - CTR;
              nc = cc + dc - CTR;
              if (nr >= 0 && nr < eh && nc >= 0 && nc < ew && win_px[dr][dc] > centre)
                res.code[CODE_W-1-idx] = 1'b1;
              idx++;
            end
          end
        end
      end
      res.row = cr[POS_W-1:0];
      res.col = cc[POS_W-1:0];
      res.last = frame_end;
      pending_codes.push_back(res);
    end

    if (frame_end) begin
      scan_r = 0;
      scan_c = 0;
    end else if (row_end) begin
      scan_c = 0;
      scan_r = scan_r + 1;
    end else begin
      scan_c = scan_c + 1;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: each transfer against the oldest expected code
  census_result_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d", center_row, center_col));
      end else begin
        want = pending_codes.pop_front();
        if (census_code !== want.code || center_row !== want.row ||
            center_col !== want.col || frame_last !== want.last)
          report_mismatch($sformatf("got code %h r%0d c%0d last %b, want %h r%0d c%0d last %b",
                                    census_code, center_row, center_col, frame_last,
                                    want.code, want.row, want.col, want.last));
      end
    end
  end

  // One pixel transfer, with a random gap ahead of it
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= v;
    do @(posedge clk); while (!in_ready);
    census_predict(v);
    items_sent++;
  endtask

  // Stop sending and wait until every expected code is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == ct8_pkg::REG_WIDTH) width_reg = val;
    else if (idx == ct8_pkg::REG_HEIGHT) height_reg = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input pix_style_t style);
    int t;
    case (style)
      PIX_NEAR: begin
        t = int'(px_base) + int'($urandom_range(4)) - 2;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[PIX_W-1:0];
      end
      PIX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixels(input int n, input pix_style_t style);
    repeat (n) send_pixel(pick_pixel(style));
  endtask

  // Send until the scan wraps back to the frame start
  task automatic finish_frame(input pix_style_t style);
    do send_pixel(pick_pixel(style)); while (scan_r != 0 || scan_c != 0);
  endtask

  task automatic run_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input pix_style_t style);
    wait_idle();
    write_cfg(ct8_pkg::REG_WIDTH, w);
    write_cfg(ct8_pkg::REG_HEIGHT, h);
    px_base = PIX_W'($urandom_range(255));
    finish_frame(style);
  endtask

  // 2x2 image: checkerboard of the pixel extremes, equal and unequal neighbors
  task automatic test_directed();
    wait_idle();
    write_cfg(ct8_pkg::REG_WIDTH, 11'd2);
    write_cfg(ct8_pkg::REG_HEIGHT, 11'd2);
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (r < 2 && c < 2) send_pixel(((r + c) % 2 == 0) ? 8'hFF : 8'h00);
        else send_pixel(PIX_W'($urandom_range(255)));
      end
    end
  endtask

  // Zero size, single column and single row images, spare index
  task automatic test_size_extremes();
    run_frame(11'd0, 11'd0, PIX_UNIFORM);
    run_frame(11'd0, 11'd5, PIX_BINARY);
    wait_idle();
    write_cfg(REG_SPARE, 11'd2047);
    finish_frame(PIX_UNIFORM);
    run_frame(11'd5, 11'd1, PIX_UNIFORM);
    wait_idle();
    write_cfg(REG_SPARE, 11'd0);
    run_frame(11'd3, 11'd2, PIX_UNIFORM);
  endtask

  // Height change while a frame is under way
  task automatic test_midframe_height();
    // shrink: frame ends at the end of the current row
    run_frame(11'd4, 11'd8, PIX_UNIFORM);
    wait_idle();
    write_cfg(ct8_pkg::REG_HEIGHT, 11'd8);
    send_pixels(5 * 7, PIX_UNIFORM);
    wait_idle();
    write_cfg(ct8_pkg::REG_HEIGHT, 11'd3);
    finish_frame(PIX_UNIFORM);
    // grow while still inside the image rows
    run_frame(11'd4, 11'd3, PIX_NEAR);
    send_pixels(2 * 7, PIX_UNIFORM);
    wait_idle();
    write_cfg(ct8_pkg::REG_HEIGHT, 11'd6);
    finish_frame(PIX_UNIFORM);
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    wait_idle();
    write_cfg(ct8_pkg::REG_WIDTH, 11'd8);
    write_cfg(ct8_pkg::REG_HEIGHT, 11'd8);
    hold_req = 300;
    finish_frame(PIX_UNIFORM);
    hold_req = 150;
    run_frame(11'd5, 11'd3, PIX_NEAR);
  endtask

  // Random sizes, mostly small, random pixel content
  task automatic test_random_frames(input int n_items);
    int               start;
    logic [CFG_W-1:0] w, h;
    pix_style_t       style;
    start = items_sent;
    while (items_sent - start < n_items) begin
      w = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(40, 13)) :
                                     CFG_W'($urandom_range(12, 1));
      h = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(40, 13)) :
                                     CFG_W'($urandom_range(12, 1));
      if ($urandom_range(15) == 0) w = '0;
      if ($urandom_range(15) == 0) h = '0;
      style = pix_style_t'($urandom_range(2));
      run_frame(w, h, style);
    end
  endtask

  initial begin
    width_reg = ct8_pkg::WIDTH_RST;
    height_reg = ct8_pkg::HEIGHT_RST;
    scan_r = 0;
    scan_c = 0;
    for (int i = 0; i < STORE_ROWS * MAX_WIDTH; i++) line_mem[i] = '0;
    for (int i = 0; i < WIN; i++)
      for (int j = 0; j < WIN; j++) win_px[i][j] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 61;
    test_directed();
    test_size_extremes();
    test_midframe_height();
    test_random_frames(250);

    send_idle_pct = 61;
    recv_idle_pct = 30;
    test_random_frames(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_frames(250);

    wait_idle();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
